// File: rtl/core/fe2_pkg.sv
// Shared types and constants for the fast power-of-two / power-of-ten pipeline.
// Used by every module under rtl/core; depends on nothing.
package fe2_pkg;

  // Unsigned Q.30 constants
  localparam logic [29:0] COEF_C1      = 30'd744261118;
  localparam logic [29:0] COEF_C2      = 30'd257941248;
  localparam logic [29:0] COEF_C3      = 30'd59596339;
  localparam logic [31:0] LOG2_TEN_Q30 = 32'd3566893132;

  // IEEE single bit patterns for clipped results
  localparam logic [31:0] BITS_TEN_THOUSAND = 32'h461C4000;
  localparam logic [31:0] BITS_ZERO         = 32'h00000000;

  // Saturation bounds of the scaled exponent
  localparam logic [26:0] SAT_POS_MAG = 27'd8388607;
  localparam logic [26:0] SAT_NEG_MAG = 27'd8388608;

  // Payload carried between the exponent split and the output stage
  typedef struct packed {
    logic        clip;     // exponent out of range
    logic        clip_hi;  // out of range on the high side
    logic [7:0]  bexp;     // biased exponent n + 127
    logic [29:0] f30;      // fraction in Q.30
    logic [29:0] p;        // Horner partial result in Q.30
  } hz_t;

endpackage

// File: rtl/core/fe2_scale.sv
// Input stages: log2(10) scaling with saturation in mode 1, range check and exponent split.
// Depends on fe2_pkg; feeds the first Horner step.
module fe2_scale #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               valid_in,
  output logic               ready_up,
  input  logic signed [23:0] x_fixed,
  input  logic               mode,
  output logic               valid,
  input  logic               ready_dn,
  output fe2_pkg::hz_t       item
);
  import fe2_pkg::*;

  localparam logic signed [31:0] EXP_HI = 32'(127 << FRAC_BITS);
  localparam logic signed [31:0] EXP_LO = -32'(126 << FRAC_BITS);

  // Stage one registers
  logic               v1;
  logic               neg1;
  logic               mode1;
  logic signed [23:0] x1;
  logic [55:0]        prod1;

  logic        en1;
  logic        en2;
  logic [23:0] mag;

  // Stage two combinational
  logic [25:0]        q;
  logic [26:0]        qr;
  logic signed [23:0] s_scaled;
  logic signed [23:0] s;
  logic signed [31:0] s_w;
  logic signed [23:0] sn;
  hz_t                item_next;

  assign en2      = !valid || ready_dn;
  assign en1      = !v1 || en2;
  assign ready_up = en1;

  // Magnitude of x; the most negative code maps to 2^23
  assign mag = x_fixed[23] ? (~x_fixed + 24'd1) : x_fixed;

  // Capture input and form |x| * log2(10)
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= valid_in;
    end
    if (en1) begin
      neg1  <= x_fixed[23];
      mode1 <= mode;
      x1    <= x_fixed;
      prod1 <= 56'(mag) * 56'(LOG2_TEN_Q30);
    end
  end

  // Round toward minus infinity, apply sign, saturate
  always_comb begin
    q  = prod1[55:30];
    qr = 27'(q) + 27'(neg1 && (prod1[29:0] != 30'd0));
    if (!neg1) begin
      s_scaled = (qr > SAT_POS_MAG) ? 24'sh7FFFFF : qr[23:0];
    end else begin
      s_scaled = (qr > SAT_NEG_MAG) ? 24'sh800000 : (~qr[23:0] + 24'd1);
    end
    s   = mode1 ? s_scaled : x1;
    s_w = 32'(s);
    sn  = s >>> FRAC_BITS;

    item_next.clip_hi = s_w > EXP_HI;
    item_next.clip    = (s_w > EXP_HI) || (s_w < EXP_LO);
    item_next.bexp    = sn[7:0] + 8'd127;
    item_next.f30     = {s[FRAC_BITS-1:0], {(30-FRAC_BITS){1'b0}}};
    item_next.p       = 30'd0;
  end

  // Register the split exponent
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en2) begin
      valid <= v1;
    end
    if (en2) begin
      item <= item_next;
    end
  end

endmodule

// File: rtl/core/fe2_horner.sv
// One Horner step: p_out = ((p_in + COEF) * f) >> 30, truncated, in Q.30.
// Depends on fe2_pkg; three instances chain into the cubic.
module fe2_horner #(
  parameter logic [29:0] COEF = 30'd0
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         valid_in,
  output logic         ready_up,
  input  fe2_pkg::hz_t item_in,
  output logic         valid,
  input  logic         ready_dn,
  output fe2_pkg::hz_t item
);
  import fe2_pkg::*;

  logic        en;
  logic [30:0] sum;
  logic [60:0] prod;
  hz_t         item_next;

  assign en       = !valid || ready_dn;
  assign ready_up = en;

  // Add coefficient, multiply by the fraction, drop 30 bits
  always_comb begin
    sum         = 31'(item_in.p) + 31'(COEF);
    prod        = 61'(sum) * 61'(item_in.f30);
    item_next   = item_in;
    item_next.p = prod[59:30];
  end

  // Advance the stage
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      item <= item_next;
    end
  end

endmodule

// File: rtl/core/fe2_pack.sv
// Output stage: rounds the polynomial into a 23-bit mantissa, forms IEEE single bits.
// Depends on fe2_pkg; drives the result channel registers.
module fe2_pack (
  input  logic         clk,
  input  logic         rst,
  input  logic         valid_in,
  output logic         ready_up,
  input  fe2_pkg::hz_t item_in,
  output logic         valid,
  input  logic         ready_dn,
  output logic [31:0]  result_bits,
  output logic         clipped
);
  import fe2_pkg::*;

  logic        en;
  logic [30:0] rnd;
  logic [31:0] bits_next;

  assign en       = !valid || ready_dn;
  assign ready_up = en;

  // Round to nearest, ties up; a mantissa carry rolls into the exponent
  always_comb begin
    rnd = 31'(item_in.p) + 31'd64;
    if (item_in.clip) begin
      bits_next = item_in.clip_hi ? BITS_TEN_THOUSAND : BITS_ZERO;
    end else begin
      bits_next = {1'b0, item_in.bexp, 23'd0} + 32'(rnd[30:7]);
    end
  end

  // Hold the result until the transfer completes
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
    if (en) begin
      result_bits <= bits_next;
      clipped     <= item_in.clip;
    end
  end

endmodule

// File: rtl/core/fast_exp2_exp10_approx.sv
// Fast 2^x / 10^x in fixed point, returned as IEEE-754 single bits. x_fixed is a
// signed 24-bit exponent with FRAC_BITS fraction bits; mode 1 scales it by log2(10)
// first (saturating to 24 bits). Exponents above 127 return 10000.0 and below -126
// return 0.0, both with clipped set. The block is a six-stage pipeline (scale
// multiply, exponent split, three Horner multiply steps, mantissa rounding) and
// takes one item per cycle while the output is not stalled; each item passes
// through the stage registers in that order, and res_valid rises when it reaches
// the output register. Each stage holds its item while the next one is full and
// stalled, so bubbles close up and nothing is dropped or repeated.
// Depends on fe2_pkg, fe2_scale, fe2_horner and fe2_pack.
module fast_exp2_exp10_approx #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               x_valid,
  output logic               x_stall,
  input  logic signed [23:0] x_fixed,
  input  logic               mode,
  output logic               res_valid,
  input  logic               res_stall,
  output logic [31:0]        result_bits,
  output logic               clipped
);
  import fe2_pkg::*;

  logic v_sc, v_h3, v_h2, v_h1;
  logic r_sc, r_h3, r_h2, r_h1, r_pk;
  hz_t  i_sc, i_h3, i_h2, i_h1;

  assign x_stall = !r_sc;

  // Scale and split
  fe2_scale #(.FRAC_BITS(FRAC_BITS)) u_scale (
    .clk, .rst,
    .valid_in (x_valid), .ready_up (r_sc),
    .x_fixed, .mode,
    .valid (v_sc), .ready_dn (r_h3), .item (i_sc)
  );

  // Horner cubic, innermost coefficient first
  fe2_horner #(.COEF(COEF_C3)) u_h3 (
    .clk, .rst,
    .valid_in (v_sc), .ready_up (r_h3), .item_in (i_sc),
    .valid (v_h3), .ready_dn (r_h2), .item (i_h3)
  );

  fe2_horner #(.COEF(COEF_C2)) u_h2 (
    .clk, .rst,
    .valid_in (v_h3), .ready_up (r_h2), .item_in (i_h3),
    .valid (v_h2), .ready_dn (r_h1), .item (i_h2)
  );

  fe2_horner #(.COEF(COEF_C1)) u_h1 (
    .clk, .rst,
    .valid_in (v_h2), .ready_up (r_h1), .item_in (i_h2),
    .valid (v_h1), .ready_dn (r_pk), .item (i_h1)
  );

  // Mantissa rounding and output register
  fe2_pack u_pack (
    .clk, .rst,
    .valid_in (v_h1), .ready_up (r_pk), .item_in (i_h1),
    .valid (res_valid), .ready_dn (!res_stall),
    .result_bits, .clipped
  );

  // A clipped result is exactly one of the two fixed patterns
  a_clip_value: assert property (@(posedge clk) disable iff (rst)
    res_valid && clipped |->
      (result_bits == BITS_TEN_THOUSAND) || (result_bits == BITS_ZERO))
    else $error("clipped result has unexpected bits");

  // An in-range result is a positive normal number
  a_normal: assert property (@(posedge clk) disable iff (rst)
    res_valid && !clipped |-> !result_bits[31] && (result_bits[30:23] != 8'd0))
    else $error("in-range result is not a positive normal");

  // Input can only be held off when the whole pipe backs up from the output
  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    x_stall |-> res_valid && res_stall)
    else $error("input stalled while output is free");

endmodule
